// ===== src/mmrs_pkg.sv =====
// shared types and constants for the modular multiple min residue scan
// no dependencies; compile first
package mmrs_pkg;

  localparam int N_BITS    = 6;
  localparam int D_BITS    = 17;
  localparam int NUM_CAPS  = 3;
  localparam int CAP2_BITS = 2 * N_BITS;
  localparam int CAP3_BITS = 3 * N_BITS;

  localparam logic [N_BITS-1:0] N_MIN = N_BITS'(1);
  localparam logic [N_BITS-1:0] N_MAX = N_BITS'(47);

  localparam int CAP_LINEAR = 0;
  localparam int CAP_SQUARE = 1;
  localparam int CAP_CUBE   = 2;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic pow_step;
    logic euc_init;
    logic div_start;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic scan_init;
    logic scan_step;
    logic set_trivial;
    logic finish;
  } ctl_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic q_small;
    logic pow_done;
    logic nr_zero;
    logic div_last;
    logic mul_last;
    logic scan_last;
    logic out_free;
  } ctl_status_t;

endpackage

// ===== src/mmrs_if.sv =====
// valid/ready channel interfaces for input items and results
// depends on mmrs_pkg
interface mmrs_in_if #(
  parameter int P_BITS = 22,
  parameter int Q_BITS = 23
);
  import mmrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [P_BITS-1:0] prime_p;
  logic [Q_BITS-1:0] prime_q;
  logic [N_BITS-1:0] bit_length;

  modport source (output valid, prime_p, prime_q, bit_length, input ready);
  modport sink (input valid, prime_p, prime_q, bit_length, output ready);
endinterface

interface mmrs_out_if #(
  parameter int P_BITS = 22,
  parameter int Q_BITS = 23
);
  import mmrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [Q_BITS-1:0] multiplier_a;
  logic [P_BITS-1:0] best_res_linear;
  logic [D_BITS-1:0] best_d_linear;
  logic [P_BITS-1:0] best_res_square;
  logic [D_BITS-1:0] best_d_square;
  logic [P_BITS-1:0] best_res_cube;
  logic [D_BITS-1:0] best_d_cube;
  logic              record_linear;
  logic              record_square;
  logic              record_cube;

  modport source (
    output valid, multiplier_a, best_res_linear, best_d_linear, best_res_square,
           best_d_square, best_res_cube, best_d_cube, record_linear, record_square,
           record_cube,
    input  ready
  );
  modport sink (
    input  valid, multiplier_a, best_res_linear, best_d_linear, best_res_square,
           best_d_square, best_res_cube, best_d_cube, record_linear, record_square,
           record_cube,
    output ready
  );
endinterface

// ===== src/modular_multiple_min_residue_scan.sv =====
// Each item with q >= 2 runs through the power, extended Euclid, multiply and scan phases; the
// scan dominates, one multiple d*a mod q per cycle through a single modular adder, for d from
// 1 to n^3 where n is the saturated bit length. One item is in work at a time; a
// new item is taken as soon as the previous one has been moved to the output register,
// which holds it until the result transfer. Running maxima are cleared by reset only.
// depends on mmrs_pkg, mmrs_if, mmrs_ctrl, mmrs_datapath
module modular_multiple_min_residue_scan #(
  parameter int P_BITS = 22,
  parameter int Q_BITS = 23
) (
  input logic        clk,
  input logic        rst,
  mmrs_in_if.sink    items,
  mmrs_out_if.source results
);
  import mmrs_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;
  logic        ctl_ready;

  assign items.ready = ctl_ready;

  mmrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (items.valid),
    .ready  (ctl_ready),
    .status (status),
    .cmd    (cmd)
  );

  mmrs_datapath #(
    .P_BITS (P_BITS),
    .Q_BITS (Q_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .prime_p    (items.prime_p),
    .prime_q    (items.prime_q),
    .bit_length (items.bit_length),
    .results    (results)
  );

endmodule

// ===== src/mmrs_ctrl.sv =====
// sequencer: walks one item through power, euclid, multiply, scan and output
// depends on mmrs_pkg
module mmrs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  ready,
  input  mmrs_pkg::ctl_status_t status,
  output mmrs_pkg::ctl_cmd_t    cmd
);
  import mmrs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_POW       = 9'b000000010,
    S_EUC_CHK   = 9'b000000100,
    S_EUC_DIV   = 9'b000001000,
    S_MUL       = 9'b000010000,
    S_SCAN_INIT = 9'b000100000,
    S_SCAN      = 9'b001000000,
    S_DRAIN     = 9'b010000000,
    S_DONE      = 9'b100000000
  } ctl_state_t;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    ready      = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_POW;
        end
      end
      S_POW: begin
        if (status.q_small) begin
          cmd.set_trivial = 1'b1;
          state_next      = S_DONE;
        end else if (status.pow_done) begin
          cmd.euc_init = 1'b1;
          state_next   = S_EUC_CHK;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      S_EUC_CHK: begin
        if (status.nr_zero) begin
          cmd.mul_init = 1'b1;
          state_next   = S_MUL;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_EUC_DIV;
        end
      end
      S_EUC_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_EUC_CHK;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_next = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last folded residue reaches the best registers here
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mmrs_datapath.sv =====
// datapath: modular doubling, bit-serial extended euclid, shift-add modmul,
// one-multiple-per-cycle residue scan, running maxima and output register
// depends on mmrs_pkg and mmrs_if
module mmrs_datapath #(
  parameter int P_BITS = 22,
  parameter int Q_BITS = 23
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mmrs_pkg::ctl_cmd_t            cmd,
  output mmrs_pkg::ctl_status_t         status,
  input  logic [P_BITS-1:0]             prime_p,
  input  logic [Q_BITS-1:0]             prime_q,
  input  logic [mmrs_pkg::N_BITS-1:0]   bit_length,
  mmrs_out_if.source                    results
);
  import mmrs_pkg::*;

  localparam int CW     = Q_BITS + 2;
  localparam int DIV_CW = $clog2(Q_BITS);
  localparam int MUL_CW = $clog2(P_BITS);

  // item registers
  logic [P_BITS-1:0]    p;
  logic [Q_BITS-1:0]    q;
  logic [N_BITS-1:0]    n;
  logic [N_BITS-1:0]    n_sat;
  logic [Q_BITS:0]      qx;
  logic [CW-1:0]        q_cw;

  // caps
  logic [CAP2_BITS-1:0] cap2;
  logic [D_BITS-1:0]    cap3;
  logic [CAP3_BITS-1:0] cap3_full;
  logic [D_BITS-1:0]    cap [NUM_CAPS];

  // power of two mod q
  logic [Q_BITS-1:0]    x;
  logic [N_BITS-2:0]    pow_cnt;
  logic [Q_BITS:0]      x2;
  logic [Q_BITS:0]      x2r;

  // extended euclid
  logic [Q_BITS-1:0]       r;
  logic [Q_BITS-1:0]       nr;
  logic signed [CW-1:0]    t;
  logic signed [CW-1:0]    nt;
  logic [Q_BITS-1:0]       rem;
  logic signed [CW-1:0]    prod;
  logic [DIV_CW-1:0]       div_cnt;
  logic [Q_BITS:0]         rem_sh;
  logic                    quo_bit;
  logic [Q_BITS:0]         rem_new;
  logic signed [CW-1:0]    prod_new;

  // modular multiply
  logic signed [CW-1:0] t_pos;
  logic [Q_BITS:0]      inv_full;
  logic [Q_BITS:0]      inv_red;
  logic [Q_BITS-1:0]    inv;
  logic [Q_BITS-1:0]    acc;
  logic [MUL_CW-1:0]    mul_cnt;
  logic [Q_BITS:0]      acc2;
  logic [Q_BITS:0]      acc2r;
  logic [Q_BITS:0]      sum;
  logic [Q_BITS:0]      sumr;

  // scan
  logic [Q_BITS-1:0]    a;
  logic [Q_BITS-1:0]    v;
  logic [D_BITS-1:0]    d;
  logic [Q_BITS:0]      v_sum;
  logic [Q_BITS:0]      v_red;
  logic [Q_BITS-1:0]    w;
  logic [Q_BITS-1:0]    fold;
  logic [Q_BITS-1:0]    r_s;
  logic [D_BITS-1:0]    d_s;
  logic                 s_valid;
  logic [Q_BITS-1:0]    best   [NUM_CAPS];
  logic [D_BITS-1:0]    best_d [NUM_CAPS];

  // records and output
  logic [P_BITS-1:0]    run_max [NUM_CAPS];
  logic [P_BITS-1:0]    res_m   [NUM_CAPS];
  logic [NUM_CAPS-1:0]  rec;
  logic                 out_valid;
  logic [Q_BITS-1:0]    out_a;
  logic [P_BITS-1:0]    out_res [NUM_CAPS];
  logic [D_BITS-1:0]    out_d   [NUM_CAPS];
  logic [NUM_CAPS-1:0]  out_rec;

  always_comb begin
    if (bit_length < N_MIN) begin
      n_sat = N_MIN;
    end else if (bit_length > N_MAX) begin
      n_sat = N_MAX;
    end else begin
      n_sat = bit_length;
    end
  end

  assign qx   = {1'b0, q};
  assign q_cw = {2'b00, q};

  assign cap3_full       = CAP3_BITS'(cap2) * CAP3_BITS'(n);
  assign cap[CAP_LINEAR] = D_BITS'(n);
  assign cap[CAP_SQUARE] = D_BITS'(cap2);
  assign cap[CAP_CUBE]   = cap3;

  // doubling mod q
  assign x2  = {x, 1'b0};
  assign x2r = (x2 >= qx) ? (x2 - qx) : x2;

  // one quotient bit per cycle; the coefficient product is built alongside
  assign rem_sh   = {rem, r[div_cnt]};
  assign quo_bit  = (rem_sh >= {1'b0, nr});
  assign rem_new  = quo_bit ? (rem_sh - {1'b0, nr}) : rem_sh;
  assign prod_new = (prod <<< 1) + (quo_bit ? nt : '0);

  // final coefficient into 0..q-1
  assign t_pos    = t[CW-1] ? (t + q_cw) : t;
  assign inv_full = t_pos[Q_BITS:0];
  assign inv_red  = (inv_full >= qx) ? (inv_full - qx) : inv_full;

  // horner step over the bits of p
  assign acc2  = {acc, 1'b0};
  assign acc2r = (acc2 >= qx) ? (acc2 - qx) : acc2;
  assign sum   = acc2r + (p[mul_cnt] ? {1'b0, inv} : '0);
  assign sumr  = (sum >= qx) ? (sum - qx) : sum;

  // next multiple and its fold
  assign v_sum = {1'b0, v} + {1'b0, a};
  assign v_red = (v_sum >= qx) ? (v_sum - qx) : v_sum;
  assign w     = q - v;
  assign fold  = (v < w) ? v : w;

  always_comb begin
    for (int j = 0; j < NUM_CAPS; j++) begin
      res_m[j] = P_BITS'(best[j]);
      rec[j]   = (res_m[j] > run_max[j]);
    end
  end

  assign status.q_small   = (q < Q_BITS'(2));
  assign status.pow_done  = (pow_cnt == '0);
  assign status.nr_zero   = (nr == '0);
  assign status.div_last  = (div_cnt == '0);
  assign status.mul_last  = (mul_cnt == '0);
  assign status.scan_last = (d == cap3);
  assign status.out_free  = !out_valid || results.ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < NUM_CAPS; j++) begin
        run_max[j] <= '0;
      end
    end else begin
      s_valid <= cmd.scan_step;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        for (int j = 0; j < NUM_CAPS; j++) begin
          if (rec[j]) begin
            run_max[j] <= res_m[j];
          end
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, caps, power and euclid registers
  always_ff @(posedge clk) begin
    cap2 <= CAP2_BITS'(n) * CAP2_BITS'(n);
    cap3 <= D_BITS'(cap3_full);
    if (cmd.load) begin
      p       <= prime_p;
      q       <= prime_q;
      n       <= n_sat;
      x       <= Q_BITS'(1);
      pow_cnt <= n_sat[N_BITS-1:1];
    end
    if (cmd.pow_step) begin
      x       <= x2r[Q_BITS-1:0];
      pow_cnt <= pow_cnt - 1'b1;
    end
    if (cmd.euc_init) begin
      r  <= q;
      nr <= x;
      t  <= '0;
      nt <= CW'(1);
    end
    if (cmd.div_start) begin
      rem     <= '0;
      prod    <= '0;
      div_cnt <= DIV_CW'(Q_BITS - 1);
    end
    if (cmd.div_step) begin
      rem     <= rem_new[Q_BITS-1:0];
      prod    <= prod_new;
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == '0) begin
        r  <= nr;
        nr <= rem_new[Q_BITS-1:0];
        t  <= nt;
        nt <= t - prod_new;
      end
    end
  end

  // multiply, scan and output registers
  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      inv     <= inv_red[Q_BITS-1:0];
      acc     <= '0;
      mul_cnt <= MUL_CW'(P_BITS - 1);
    end
    if (cmd.mul_step) begin
      acc     <= sumr[Q_BITS-1:0];
      mul_cnt <= mul_cnt - 1'b1;
    end
    if (cmd.scan_init) begin
      a <= acc;
      v <= acc;
      d <= D_BITS'(1);
      for (int j = 0; j < NUM_CAPS; j++) begin
        best[j]   <= '1;
        best_d[j] <= '0;
      end
    end
    if (cmd.scan_step) begin
      v   <= v_red[Q_BITS-1:0];
      d   <= d + 1'b1;
      r_s <= fold;
      d_s <= d;
    end
    if (s_valid) begin
      for (int j = 0; j < NUM_CAPS; j++) begin
        if ((d_s <= cap[j]) && (r_s < best[j])) begin
          best[j]   <= r_s;
          best_d[j] <= d_s;
        end
      end
    end
    if (cmd.set_trivial) begin
      a <= '0;
      for (int j = 0; j < NUM_CAPS; j++) begin
        best[j]   <= '0;
        best_d[j] <= D_BITS'(1);
      end
    end
    if (cmd.finish) begin
      out_a   <= a;
      out_rec <= rec;
      for (int j = 0; j < NUM_CAPS; j++) begin
        out_res[j] <= res_m[j];
        out_d[j]   <= best_d[j];
      end
    end
  end

  assign results.valid           = out_valid;
  assign results.multiplier_a    = out_a;
  assign results.best_res_linear = out_res[CAP_LINEAR];
  assign results.best_d_linear   = out_d[CAP_LINEAR];
  assign results.best_res_square = out_res[CAP_SQUARE];
  assign results.best_d_square   = out_d[CAP_SQUARE];
  assign results.best_res_cube   = out_res[CAP_CUBE];
  assign results.best_d_cube     = out_d[CAP_CUBE];
  assign results.record_linear   = out_rec[CAP_LINEAR];
  assign results.record_square   = out_rec[CAP_SQUARE];
  assign results.record_cube     = out_rec[CAP_CUBE];

  a_scan_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (v < q))
    else $error("scan multiple not reduced mod q");

  a_scan_in_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (d <= cap3))
    else $error("scan ran past the cube cap");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (nr != '0) && (rem < nr))
    else $error("division remainder out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!results.valid || results.ready))
    else $error("result loaded over an untaken result");

endmodule
